@@ rtl/b32m_pkg.sv @@
`default_nettype none

package b32m_pkg;

  // Longest prefix the encoder stores
  localparam int HRP_MAX_DEF = 83;

  // Item kinds on the input channel
  typedef enum logic [1:0] {
    CMD_PREFIX  = 2'd0,
    CMD_VERSION = 2'd1,
    CMD_BYTE    = 2'd2,
    CMD_RSVD    = 2'd3
  } item_cmd_t;

  // Source of the character loaded into the output register
  typedef enum logic [2:0] {
    EM_ECHO,
    EM_ERR,
    EM_SEP,
    EM_SYM,
    EM_CK
  } emit_sel_t;

  // Source of the 5-bit symbol fed to the checksum and the alphabet
  typedef enum logic [2:0] {
    SY_PFX_HI,
    SY_ZERO,
    SY_MEM,
    SY_VER,
    SY_DATA,
    SY_PAD
  } sym_sel_t;

  // Controller to datapath
  typedef struct packed {
    logic      load;
    logic      clear;
    logic      err_set;
    logic      phase_set;
    logic      mem_wr;
    logic      step;
    sym_sel_t  sym_sel;
    logic      emit;
    emit_sel_t emit_sel;
    logic      idx_clr;
    logic      idx_inc;
    logic      buf_load;
    logic      cnt_sub;
    logic      k_clr;
    logic      k_inc;
    logic      ck_xor;
    logic      ck_shift;
  } b32m_cmd_t;

  // Datapath to controller
  typedef struct packed {
    item_cmd_t kind;
    logic      last;
    logic      val_hi;
    logic      phase;
    logic      err_seen;
    logic      hrp_full;
    logic      idx_end;
    logic      cnt_ge5;
    logic      cnt_nz;
    logic      k_end;
    logic      out_free;
  } b32m_stat_t;

  localparam logic [29:0] GEN_POLY [5] = '{
    30'h3B6A57B2, 30'h26508E6D, 30'h1EA119FA, 30'h3D4233DD, 30'h2A1462B3
  };
  localparam logic [29:0] BECH32M_XOR = 30'h2BC830A3;
  localparam logic [29:0] CK_INIT     = 30'd1;
  localparam logic [6:0]  SEP_CHAR    = 7'h31;  // '1'

  // "qpzry9x8gf2tvdw0s3jn54khce6mua7l"
  localparam logic [6:0] ALPHABET [32] = '{
    7'h71, 7'h70, 7'h7A, 7'h72, 7'h79, 7'h39, 7'h78, 7'h38,
    7'h67, 7'h66, 7'h32, 7'h74, 7'h76, 7'h64, 7'h77, 7'h30,
    7'h73, 7'h33, 7'h6A, 7'h6E, 7'h35, 7'h34, 7'h6B, 7'h68,
    7'h63, 7'h65, 7'h36, 7'h6D, 7'h75, 7'h61, 7'h37, 7'h6C
  };

  // One BCH polymod step: shift in a symbol, fold back the five top bits
  function automatic logic [29:0] poly_step(input logic [29:0] acc, input logic [4:0] sym);
    logic [29:0] r;
    r = {acc[24:0], sym};
    for (int i = 0; i < 5; i++) begin
      if (acc[25+i]) r = r ^ GEN_POLY[i];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/b32m_dp.sv @@
`default_nettype none

module b32m_dp import b32m_pkg::*; #(
  parameter int HRP_MAX = HRP_MAX_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire b32m_cmd_t  cmd,
  output b32m_stat_t      stat,
  input  wire logic [1:0] in_command,
  input  wire logic [7:0] in_value,
  input  wire logic       in_last,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [6:0]      out_char,
  output logic            out_end_of_address,
  output logic            out_error
);

  localparam int LENW = $clog2(HRP_MAX + 1);
  localparam int IDXW = (HRP_MAX > 1) ? $clog2(HRP_MAX) : 1;

  // Held item
  logic [1:0]      kind_r;
  logic [7:0]      val_r;
  logic            last_r;

  // Address state
  logic [29:0]     acc_r;
  logic [11:0]     buf_r;
  logic [3:0]      cnt_r;
  logic [LENW-1:0] len_r;
  logic [LENW-1:0] idx_r;
  logic            phase_r;
  logic            err_r;
  logic [2:0]      k_r;

  // Prefix low-part store
  logic [4:0]      prefix_mem [HRP_MAX];
  logic [4:0]      rd_data_r;

  // Output register
  logic            out_valid_r;
  logic [6:0]      out_char_r;
  logic            out_end_r;
  logic            out_err_r;

  logic [4:0]      sym;
  logic [2:0]      data_sh;
  logic [8:0]      pad_ext;
  logic [6:0]      char_nxt;
  logic            end_nxt;
  logic            out_free;

  assign data_sh  = 3'(cnt_r - 4'd5);
  assign pad_ext  = {5'd0, buf_r[3:0]} << (3'd5 - cnt_r[2:0]);
  assign out_free = !out_valid_r || out_ready;

  // Symbol select
  always_comb begin
    unique case (cmd.sym_sel)
      SY_PFX_HI: sym = {2'd0, val_r[7:5]};
      SY_ZERO:   sym = 5'd0;
      SY_MEM:    sym = rd_data_r;
      SY_VER:    sym = val_r[4:0];
      SY_DATA:   sym = 5'(buf_r >> data_sh);
      SY_PAD:    sym = pad_ext[4:0];
      default:   sym = 5'd0;
    endcase
  end

  // Character select for the next beat
  always_comb begin
    end_nxt = 1'b0;
    unique case (cmd.emit_sel)
      EM_ECHO: char_nxt = val_r[6:0];
      EM_ERR: begin
        char_nxt = 7'd0;
        end_nxt  = last_r;
      end
      EM_SEP:  char_nxt = SEP_CHAR;
      EM_SYM:  char_nxt = ALPHABET[sym];
      EM_CK: begin
        char_nxt = ALPHABET[acc_r[29:25]];
        end_nxt  = (k_r == 3'd5);
      end
      default: char_nxt = 7'd0;
    endcase
  end

  // Control state of the address
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= CK_INIT;
      buf_r       <= '0;
      cnt_r       <= '0;
      len_r       <= '0;
      phase_r     <= 1'b0;
      err_r       <= 1'b0;
      idx_r       <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clear) begin
        acc_r   <= CK_INIT;
        buf_r   <= '0;
        cnt_r   <= '0;
        len_r   <= '0;
        phase_r <= 1'b0;
        err_r   <= 1'b0;
      end else begin
        if (cmd.ck_xor)            acc_r <= acc_r ^ BECH32M_XOR;
        else if (cmd.ck_shift)     acc_r <= {acc_r[24:0], 5'd0};
        else if (cmd.step)         acc_r <= poly_step(acc_r, sym);
        if (cmd.err_set)   err_r   <= 1'b1;
        if (cmd.phase_set) phase_r <= 1'b1;
        if (cmd.mem_wr)    len_r   <= len_r + LENW'(1);
        if (cmd.buf_load) begin
          buf_r <= {buf_r[3:0], val_r};
          cnt_r <= cnt_r + 4'd8;
        end else if (cmd.cnt_sub) begin
          cnt_r <= cnt_r - 4'd5;
        end
      end
      if (cmd.idx_clr)      idx_r <= '0;
      else if (cmd.idx_inc) idx_r <= idx_r + LENW'(1);
      if (cmd.k_clr)        k_r   <= '0;
      else if (cmd.k_inc)   k_r   <= k_r + 3'd1;
      if (cmd.emit)         out_valid_r <= 1'b1;
      else if (out_ready)   out_valid_r <= 1'b0;
    end
  end

  // Payload registers and prefix store
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_command;
      val_r  <= in_value;
      last_r <= in_last;
    end
    if (cmd.emit) begin
      out_char_r <= char_nxt;
      out_end_r  <= end_nxt;
      out_err_r  <= (cmd.emit_sel == EM_ERR);
    end
    if (cmd.mem_wr) prefix_mem[len_r[IDXW-1:0]] <= val_r[4:0];
    rd_data_r <= prefix_mem[idx_r[IDXW-1:0]];
  end

  assign stat.kind     = item_cmd_t'(kind_r);
  assign stat.last     = last_r;
  assign stat.val_hi   = |val_r[7:5];
  assign stat.phase    = phase_r;
  assign stat.err_seen = err_r;
  assign stat.hrp_full = (len_r >= LENW'(HRP_MAX));
  assign stat.idx_end  = (idx_r == len_r);
  assign stat.cnt_ge5  = (cnt_r >= 4'd5);
  assign stat.cnt_nz   = (cnt_r != 4'd0);
  assign stat.k_end    = (k_r == 3'd5);
  assign stat.out_free = out_free;

  assign out_valid          = out_valid_r;
  assign out_char           = out_char_r;
  assign out_end_of_address = out_end_r;
  assign out_error          = out_err_r;

endmodule

`default_nettype wire

@@ rtl/b32m_ctrl.sv @@
`default_nettype none

module b32m_ctrl import b32m_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire b32m_stat_t stat,
  output b32m_cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_ERR, S_PFX, S_VZERO, S_VRD, S_VSTEP, S_VSEP,
    S_VSYM, S_BLOAD, S_BSYM, S_FIN, S_PAD, S_ZSTEP, S_XOR, S_CK
  } state_t;

  state_t state_r, state_nxt;
  logic   bad;

  // Out-of-order, out-of-range and reserved items
  always_comb begin
    unique case (stat.kind)
      CMD_PREFIX:  bad = stat.phase || stat.last || stat.hrp_full;
      CMD_VERSION: bad = stat.phase || stat.val_hi;
      CMD_BYTE:    bad = !stat.phase;
      default:     bad = 1'b1;
    endcase
  end

  assign in_ready = (state_r == S_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.sym_sel  = SY_ZERO;
    cmd.emit_sel = EM_SYM;
    unique case (state_r)
      S_IDLE: begin
        cmd.load = in_valid;
        if (in_valid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        priority if (stat.err_seen) begin
          cmd.clear = stat.last;
          state_nxt = S_IDLE;
        end else if (bad) begin
          state_nxt = S_ERR;
        end else if (stat.kind == CMD_PREFIX) begin
          state_nxt = S_PFX;
        end else if (stat.kind == CMD_VERSION) begin
          state_nxt = S_VZERO;
        end else begin
          state_nxt = S_BLOAD;
        end
      end
      S_ERR: begin
        cmd.emit_sel = EM_ERR;
        if (stat.out_free) begin
          cmd.emit    = 1'b1;
          cmd.clear   = stat.last;
          cmd.err_set = !stat.last;
          state_nxt   = S_IDLE;
        end
      end
      S_PFX: begin
        cmd.emit_sel = EM_ECHO;
        cmd.sym_sel  = SY_PFX_HI;
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          cmd.mem_wr = 1'b1;
          cmd.step   = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      // Separator zero, then replay of the stored low parts
      S_VZERO: begin
        cmd.step    = 1'b1;
        cmd.idx_clr = 1'b1;
        state_nxt   = S_VRD;
      end
      S_VRD: begin
        state_nxt = stat.idx_end ? S_VSEP : S_VSTEP;
      end
      S_VSTEP: begin
        cmd.sym_sel = SY_MEM;
        cmd.step    = 1'b1;
        cmd.idx_inc = 1'b1;
        state_nxt   = S_VRD;
      end
      S_VSEP: begin
        cmd.emit_sel = EM_SEP;
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_VSYM;
        end
      end
      S_VSYM: begin
        cmd.sym_sel = SY_VER;
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.step      = 1'b1;
          cmd.phase_set = 1'b1;
          state_nxt     = S_FIN;
        end
      end
      S_BLOAD: begin
        cmd.buf_load = 1'b1;
        state_nxt    = S_BSYM;
      end
      // One 5-bit group per beat while enough bits are buffered
      S_BSYM: begin
        cmd.sym_sel = SY_DATA;
        if (!stat.cnt_ge5) begin
          state_nxt = S_FIN;
        end else if (stat.out_free) begin
          cmd.emit    = 1'b1;
          cmd.step    = 1'b1;
          cmd.cnt_sub = 1'b1;
        end
      end
      S_FIN: begin
        cmd.k_clr = 1'b1;
        priority if (!stat.last) state_nxt = S_IDLE;
        else if (stat.cnt_nz)    state_nxt = S_PAD;
        else                     state_nxt = S_ZSTEP;
      end
      S_PAD: begin
        cmd.sym_sel = SY_PAD;
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          cmd.step  = 1'b1;
          state_nxt = S_ZSTEP;
        end
      end
      // Six zero symbols
      S_ZSTEP: begin
        cmd.step  = 1'b1;
        cmd.k_inc = 1'b1;
        if (stat.k_end) state_nxt = S_XOR;
      end
      S_XOR: begin
        cmd.ck_xor = 1'b1;
        cmd.k_clr  = 1'b1;
        state_nxt  = S_CK;
      end
      S_CK: begin
        cmd.emit_sel = EM_CK;
        if (stat.out_free) begin
          cmd.emit     = 1'b1;
          cmd.ck_shift = 1'b1;
          cmd.k_inc    = 1'b1;
          if (stat.k_end) begin
            cmd.clear = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/bech32m_address_encoder_core.sv @@
`default_nettype none

// Channel  | ports                                          | dir | accepted when
// input    | in_command, in_value, in_last                  | in  | in_valid && in_ready
// result   | out_char, out_end_of_address, out_error        | out | out_valid && out_ready
//
// One item at a time; in_ready is high only while the controller is idle.
// A version replays an L-character prefix through the one-read-port prefix store, reading and then
// stepping each stored character. A last item adds an optional pad, six polymod steps, six checksum beats.
// Each result beat waits while the output register is full and out_ready is low.
// Reset (rst_n low, synchronous) returns the encoder to the start of an address.

module bech32m_address_encoder_core import b32m_pkg::*; #(
  parameter int HRP_MAX = HRP_MAX_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] in_command,
  input  wire logic [7:0] in_value,
  input  wire logic       in_last,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [6:0]      out_char,
  output logic            out_end_of_address,
  output logic            out_error
);

  b32m_cmd_t  cmd;
  b32m_stat_t stat;

  b32m_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  b32m_dp #(
    .HRP_MAX (HRP_MAX)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_command         (in_command),
    .in_value           (in_value),
    .in_last            (in_last),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_char           (out_char),
    .out_end_of_address (out_end_of_address),
    .out_error          (out_error)
  );

endmodule

`default_nettype wire

@@ rtl/b32m_checker.sv @@
`default_nettype none

module b32m_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic [1:0] in_command,
  input wire logic [7:0] in_value,
  input wire logic       in_last,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [6:0] out_char,
  input wire logic       out_end_of_address,
  input wire logic       out_error
);

  // No result beat right after reset
  a_rst_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat right after reset");

  // Only one item in flight: ready drops after each accepted beat
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted back to back");

  // A waiting input beat holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=>
      in_valid && $stable(in_command) && $stable(in_value) && $stable(in_last))
    else $error("waiting input beat changed");

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_char) && $stable(out_end_of_address) && $stable(out_error))
    else $error("stalled result beat changed");

  // Error beats carry a null character
  a_err_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |-> out_char == 7'd0)
    else $error("error beat with a character");

endmodule

bind bech32m_address_encoder_core b32m_checker u_b32m_checker (.*);

`default_nettype wire

@@ tb/sv/bech32m_address_encoder_core_tb.sv @@
module bech32m_address_encoder_core_tb import b32m_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT   = 2000;  // cycles with no beat on either channel
  localparam int RANDOM_BEATS = 40;
  localparam int QUIET_TAIL   = 200;   // longest version replay plus checksum tail

  // One beat on the result channel
  typedef struct packed {
    logic [6:0] ch;
    logic       eoa;
    logic       err;
  } addr_char_t;

  // Address encoder predictor and result scoreboard
  class addr_scoreboard;
    localparam logic [8*32-1:0] CHARSET = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";
    localparam logic [29:0]     CK_XOR_MASK = 30'h2BC830A3;

    addr_char_t  expected_q[$];
    logic [29:0] polymod;
    logic [11:0] bit_buf;
    int          bit_cnt;
    logic [4:0]  hrp_low [HRP_MAX_DEF];
    int          hrp_len;
    bit          in_data_part;
    bit          discarding;
    int          mismatches;
    int          results_seen;
    int          error_beats;

    function new();
      foreach (hrp_low[i]) hrp_low[i] = '0;
      mismatches   = 0;
      results_seen = 0;
      error_beats  = 0;
      clear_addr();
    endfunction

    function void clear_addr();
      polymod      = 30'd1;
      bit_buf      = '0;
      bit_cnt      = 0;
      hrp_len      = 0;
      in_data_part = 1'b0;
      discarding   = 1'b0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // BCH polymod: shift in one 5-bit symbol, fold the top five bits back
    function logic [29:0] mix(logic [29:0] acc, logic [4:0] sym);
      logic [29:0] r;
      r = {acc[24:0], sym};
      if (acc[25]) r ^= 30'h3B6A57B2;
      if (acc[26]) r ^= 30'h26508E6D;
      if (acc[27]) r ^= 30'h1EA119FA;
      if (acc[28]) r ^= 30'h3D4233DD;
      if (acc[29]) r ^= 30'h2A1462B3;
      return r;
    endfunction

    function logic [6:0] glyph(logic [4:0] sym);
      logic [7:0] c;
      c = CHARSET[8*(31-sym) +: 8];
      return c[6:0];
    endfunction

    function void push(logic [6:0] ch, logic eoa, logic err);
      addr_char_t b;
      b.ch  = ch;
      b.eoa = eoa;
      b.err = err;
      expected_q = {expected_q, b};
      if (err) error_beats++;
    endfunction

    function void emit_symbol(logic [4:0] sym);
      polymod = mix(polymod, sym);
      push(glyph(sym), 1'b0, 1'b0);
    endfunction

    // Notes one accepted input beat; returns 0 when the beat was ignored
    function bit note_item(item_cmd_t cmd, logic [7:0] value, logic last);
      bit          bad;
      int          cnt;
      logic [11:0] acc_bits;
      logic [29:0] tail;
      bad = 1'b0;
      if (discarding) begin
        if (last) clear_addr();
        return 1'b0;
      end
      case (cmd)
        CMD_PREFIX: begin
          if (in_data_part || last || hrp_len >= HRP_MAX_DEF) begin
            bad = 1'b1;
          end else begin
            hrp_low[hrp_len] = value[4:0];
            hrp_len++;
            polymod = mix(polymod, {2'b00, value[7:5]});
            push(value[6:0], 1'b0, 1'b0);
          end
        end
        CMD_VERSION: begin
          if (in_data_part || value > 8'd31) begin
            bad = 1'b1;
          end else begin
            // expansion: high parts already in, then zero, then all low parts
            polymod = mix(polymod, 5'd0);
            for (int i = 0; i < hrp_len; i++) polymod = mix(polymod, hrp_low[i]);
            in_data_part = 1'b1;
            push(7'h31, 1'b0, 1'b0);
            emit_symbol(value[4:0]);
          end
        end
        CMD_BYTE: begin
          if (!in_data_part) begin
            bad = 1'b1;
          end else begin
            cnt      = bit_cnt + 8;
            acc_bits = {bit_buf[3:0], value};
            while (cnt >= 5) begin
              cnt -= 5;
              emit_symbol(5'((acc_bits >> cnt) & 12'h1F));
            end
            bit_cnt = cnt;
            bit_buf = acc_bits & ((12'd1 << cnt) - 12'd1);
          end
        end
        default: bad = 1'b1;
      endcase

      if (bad) begin
        push(7'd0, last, 1'b1);
        if (last) clear_addr();
        else discarding = 1'b1;
        return 1'b1;
      end

      // end of address: pad leftover bits, then six checksum characters
      if (last) begin
        if (bit_cnt > 0) emit_symbol(5'(bit_buf << (5 - bit_cnt)));
        tail = polymod;
        repeat (6) tail = mix(tail, 5'd0);
        tail ^= CK_XOR_MASK;
        for (int k = 0; k < 6; k++)
          push(glyph(5'(tail >> (5 * (5 - k)))), k == 5, 1'b0);
        clear_addr();
      end
      return 1'b1;
    endfunction

    function void check_char(logic [6:0] ch, logic eoa, logic err);
      addr_char_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result beat: expected none, actual char=%h eoa=%b err=%b",
                 $time, ch, eoa, err);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      if (ch !== want.ch) begin
        $display("%0t: out_char expected %h actual %h", $time, want.ch, ch);
        mismatches++;
      end
      if (eoa !== want.eoa) begin
        $display("%0t: out_end_of_address expected %b actual %b", $time, want.eoa, eoa);
        mismatches++;
      end
      if (err !== want.err) begin
        $display("%0t: out_error expected %b actual %b", $time, want.err, err);
        mismatches++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] in_command = '0;
  logic [7:0] in_value = '0;
  logic       in_last = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [6:0] out_char;
  logic       out_end_of_address;
  logic       out_error;

  addr_scoreboard sb;
  bit src_idle_on  = 1'b1;
  bit sink_idle_on = 1'b1;
  int beats_sent   = 0;
  int addr_count   = 0;
  int idle_cycles  = 0;

  bech32m_address_encoder_core DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_command         (in_command),
    .in_value           (in_value),
    .in_last            (in_last),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_char           (out_char),
    .out_end_of_address (out_end_of_address),
    .out_error          (out_error)
  );

  always #1 clk = ~clk;

  // Result sink with random stall bursts
  initial begin
    forever begin
      @(posedge clk);
      if (sink_idle_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_char(out_char, out_end_of_address, out_error);
  end

  // Watchdog: no beat on either channel for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: timeout with %0d results outstanding", $time, sb.pending());
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Drive one input beat, hold until accepted, then maybe leave a gap
  task automatic send_item(item_cmd_t cmd, logic [7:0] value, logic lst);
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_value   <= value;
    in_last    <= lst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (sb.note_item(cmd, value, lst)) beats_sent++;
    if (lst) addr_count++;
    if (src_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // Hold the sender off until every expected result has come out
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_hrp_char();
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(8'h61, 8'h7A));
  endfunction

  // Address with random content, mostly well formed (now and then a version above 31)
  task automatic send_good_address(int n_hrp, int n_bytes);
    logic [7:0] ver;
    for (int i = 0; i < n_hrp; i++) send_item(CMD_PREFIX, rand_hrp_char(), 1'b0);
    ver = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(32, 255)) : 8'($urandom_range(0, 31));
    send_item(CMD_VERSION, ver, n_bytes == 0);
    for (int i = 0; i < n_bytes; i++)
      send_item(CMD_BYTE, 8'($urandom_range(0, 255)), i == n_bytes - 1);
  endtask

  // Random beats with random kinds, closed by a last beat
  task automatic send_noise_address();
    int n;
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++)
      send_item(item_cmd_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), i == n - 1);
  endtask

  initial begin
    int start_beats;
    sb = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty prefix, version carries last
    send_item(CMD_VERSION, 8'd0, 1'b1);
    // prefix chars above 127 and zero, top version, byte extremes
    send_item(CMD_PREFIX, 8'hFF, 1'b0);
    send_item(CMD_PREFIX, 8'h00, 1'b0);
    send_item(CMD_VERSION, 8'd31, 1'b0);
    send_item(CMD_BYTE, 8'h00, 1'b0);
    send_item(CMD_BYTE, 8'hFF, 1'b1);
    // version above 31, rest of the address silently dropped
    send_item(CMD_PREFIX, 8'h62, 1'b0);
    send_item(CMD_VERSION, 8'd32, 1'b0);
    send_item(CMD_BYTE, 8'h12, 1'b0);
    send_item(CMD_BYTE, 8'h34, 1'b1);
    // program byte before the version
    send_item(CMD_BYTE, 8'hAA, 1'b0);
    send_item(CMD_PREFIX, 8'h63, 1'b1);
    // last on a prefix character
    send_item(CMD_PREFIX, 8'h78, 1'b1);
    // prefix character after the version
    send_item(CMD_PREFIX, 8'h64, 1'b0);
    send_item(CMD_VERSION, 8'd1, 1'b0);
    send_item(CMD_PREFIX, 8'h65, 1'b0);
    send_item(CMD_BYTE, 8'h00, 1'b1);
    // second version
    send_item(CMD_VERSION, 8'd2, 1'b0);
    send_item(CMD_VERSION, 8'd3, 1'b1);
    // unused command
    send_item(CMD_RSVD, 8'h55, 1'b0);
    send_item(CMD_RSVD, 8'hAA, 1'b1);
    // no prefix, bytes leaving three, one and four leftover bits
    send_item(CMD_VERSION, 8'd16, 1'b0);
    send_item(CMD_BYTE, 8'h80, 1'b0);
    send_item(CMD_BYTE, 8'h01, 1'b0);
    send_item(CMD_BYTE, 8'h7F, 1'b1);
    drain_results();

    // Fill the prefix store, then one character too many
    for (int i = 0; i <= HRP_MAX_DEF; i++) send_item(CMD_PREFIX, rand_hrp_char(), 1'b0);
    send_item(CMD_VERSION, 8'd0, 1'b0);
    send_item(CMD_BYTE, 8'h5A, 1'b1);

    // Random addresses, mostly well formed
    start_beats = beats_sent;
    while (beats_sent - start_beats < RANDOM_BEATS) begin
      if (beats_sent - start_beats >= RANDOM_BEATS - 15) begin
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
      end else begin
        src_idle_on  = ($urandom_range(0, 3) != 0);
        sink_idle_on = ($urandom_range(0, 3) != 0);
      end
      if ($urandom_range(0, 7) == 0) drain_results();
      if ($urandom_range(0, 4) == 0)
        send_noise_address();
      else
        send_good_address(($urandom_range(0, 7) == 0) ? $urandom_range(7, 20)
                                                      : $urandom_range(0, 6),
                          $urandom_range(0, 10));
    end
    in_valid <= 1'b0;

    // Drain, then stay quiet long enough to catch stray beats
    while (sb.pending() != 0) @(posedge clk);
    repeat (QUIET_TAIL) @(posedge clk);

    $display("Encoded %0d addresses from %0d input beats (directed, prefix overflow, random).",
             addr_count, beats_sent);
    $display("Checked %0d result beats, %0d of them error beats.",
             sb.results_seen, sb.error_beats);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
